/* rtl/core/ple_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types and constants for the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;

   // fixed field widths of the request and response items
   localparam int FUNC_W   = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_BACK  = 3'd0,
      FN_PUSH_FRONT = 3'd1,
      FN_POP_FRONT  = 3'd2,
      FN_POP_BACK   = 3'd3,
      FN_INSERT     = 3'd4,
      FN_REMOVE_AT  = 3'd5,
      FN_READ       = 3'd6,
      FN_CLEAR      = 3'd7
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_HOLD = 1'b1
   } ctl_state_type;

   // command from controller to datapath
   typedef struct packed {
      logic exec;       // perform the accepted item this cycle
   } ctl_cmd_type;

endpackage

/* rtl/core/ple_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ctrl
// Handshake controller: tracks whether a response is pending and decides
// when a new item may be taken.
// ----------------------------------------------------------------------------
module ple_ctrl
   import ple_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output ctl_cmd_type cmd
);

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) state_in = CS_HOLD;
         end
         CS_HOLD: begin
            if (!rsp_stall && !req_valid) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = 1'b0;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            cmd.exec = req_valid;
         end
         CS_HOLD: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            cmd.exec  = req_valid && !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   a_exec_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !(state_ff == CS_HOLD && rsp_stall))
      else $error("item executed while response is blocked");

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid)
      else $error("executed item produced no response");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

endmodule

/* rtl/core/ple_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_datapath
// Chain of entry cells with the count register, op decode and the
// response registers. Insert and remove shift all cells above the
// position at once.
// ----------------------------------------------------------------------------
module ple_datapath
   import ple_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ctl_cmd_type         cmd,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [POS_W-1:0]    req_position,
   input  logic [VALUE_W-1:0]  req_value,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [CNT_W-1:0]    rsp_entry_count,
   output logic [STATUS_W-1:0] rsp_status
);

   logic [DATA_WIDTH-1:0] cells_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] cells_in [CAPACITY];
   logic [CNT_W-1:0]      count_ff, count_in;

   logic [VALUE_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]    cnt_out_ff;
   status_type          st_ff, st_in;

   func_type           fn;
   logic [CMP_W-1:0]   pos_x, cnt_x, op_pos;
   logic               is_full, is_empty, pos_gt, pos_ge;
   logic               do_open, do_close, do_clear;
   logic [DATA_WIDTH-1:0] word;

   assign fn       = func_type'(req_func);
   assign pos_x    = CMP_W'(req_position);
   assign cnt_x    = CMP_W'(count_ff);
   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign pos_gt   = (pos_x > cnt_x);
   assign pos_ge   = (pos_x >= cnt_x);
   assign word     = DATA_WIDTH'(req_value);

   // decode: status, which shift and where
   always_comb begin
      st_in    = ST_OK;
      do_open  = 1'b0;
      do_close = 1'b0;
      do_clear = 1'b0;
      op_pos   = pos_x;
      rd_in    = '0;
      unique case (fn)
         FN_PUSH_BACK: begin
            op_pos = cnt_x;
            if (is_full) st_in = ST_FULL;
            else do_open = 1'b1;
         end
         FN_PUSH_FRONT: begin
            op_pos = '0;
            if (is_full) st_in = ST_FULL;
            else do_open = 1'b1;
         end
         FN_POP_FRONT: begin
            op_pos = '0;
            if (is_empty) st_in = ST_RANGE;
            else do_close = 1'b1;
         end
         FN_POP_BACK: begin
            op_pos = cnt_x - CMP_W'(1);
            if (is_empty) st_in = ST_RANGE;
            else do_close = 1'b1;
         end
         FN_INSERT: begin
            // range check wins over full
            if (pos_gt) st_in = ST_RANGE;
            else if (is_full) st_in = ST_FULL;
            else do_open = 1'b1;
         end
         FN_REMOVE_AT: begin
            if (pos_ge) st_in = ST_RANGE;
            else do_close = 1'b1;
         end
         FN_READ: begin
            if (pos_ge) st_in = ST_RANGE;
            else rd_in = VALUE_W'(cells_ff[req_position[IDX_W-1:0]]);
         end
         FN_CLEAR: begin
            do_clear = 1'b1;
         end
         default: st_in = ST_OK;
      endcase
   end

   // per-cell next value; cells past the count are don't care
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (do_open) begin
            if (CMP_W'(i) == op_pos) cells_in[i] = word;
            else if (i > 0 && CMP_W'(i) > op_pos) cells_in[i] = cells_ff[(i > 0) ? i - 1 : 0];
         end else if (do_close) begin
            if (i < CAPACITY - 1 && CMP_W'(i) >= op_pos)
               cells_in[i] = cells_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (do_clear) count_in = '0;
      else if (do_open) count_in = count_ff + CNT_W'(1);
      else if (do_close) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         for (int i = 0; i < CAPACITY; i++) cells_ff[i] <= cells_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rd_ff      <= rd_in;
         cnt_out_ff <= count_in;
         st_ff      <= st_in;
      end
   end

   assign rsp_read_value  = rd_ff;
   assign rsp_entry_count = cnt_out_ff;
   assign rsp_status      = STATUS_W'(st_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && fn == FN_CLEAR) |=> count_ff == '0)
      else $error("clear left entries");

   a_fail_no_change: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && st_in != ST_OK) |=> $stable(count_ff))
      else $error("rejected item changed the count");

endmodule

/* rtl/core/positional_list_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// Bounded ordered list of data words with push, pop, positional insert,
// remove, read and clear. One response item per request item.
// ----------------------------------------------------------------------------
// Each request item is executed in the cycle it is accepted: the entries sit
// in a chain of cells, and an insert or remove shifts every cell above the
// position in that cycle, so one item per clock is sustained while rsp_stall
// is low. The response is registered and shows in the cycle after acceptance;
// a new item is taken while the previous response is being taken. Rejected
// requests (full, empty, position out of range) return a status and leave
// the list untouched. No clearing pass after reset: the list starts empty.
module positional_list_engine_unit
   import ple_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [POS_W-1:0]    req_position,
   input  logic [VALUE_W-1:0]  req_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [CNT_W-1:0]    rsp_entry_count,
   output logic [STATUS_W-1:0] rsp_status
);

   ctl_cmd_type cmd;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ple_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

endmodule

/* dv/ple_list_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_list_scoreboard_pkg
// Shadow copy of the positional list and the queue of replies it predicts,
// used by the list engine testbench to check every response item in order.
// ----------------------------------------------------------------------------
package ple_list_scoreboard_pkg;
   import ple_pkg::*;

   typedef struct {
      logic [VALUE_W-1:0]  read_value;
      logic [CNT_W-1:0]    entry_count;
      status_type          status;
   } list_reply_type;

   class list_scoreboard_type;
      logic [DATA_WIDTH-1:0] slots [CAPACITY];
      int unsigned           fill;
      int unsigned           peak_fill;
      list_reply_type        replies_due [$];
      int unsigned           errors;
      int unsigned           requests;
      int unsigned           replies_seen;
      int unsigned           reads_ok;
      int unsigned           full_rejects;
      int unsigned           range_rejects;

      function new();
         fill          = 0;
         peak_fill     = 0;
         errors        = 0;
         requests      = 0;
         replies_seen  = 0;
         reads_ok      = 0;
         full_rejects  = 0;
         range_rejects = 0;
      endfunction

      // shift entries at..fill-1 up one place and drop the word in
      function void open_slot(int unsigned at, logic [VALUE_W-1:0] word);
         int unsigned i;
         for (i = fill; i > at; i--)
            slots[i] = slots[i-1];
         slots[at] = word[DATA_WIDTH-1:0];
         fill++;
      endfunction

      function void close_slot(int unsigned at);
         int unsigned i;
         for (i = at; i + 1 < fill; i++)
            slots[i] = slots[i+1];
         fill--;
      endfunction

      function void note_request(func_type fn, logic [POS_W-1:0] pos,
                                 logic [VALUE_W-1:0] word);
         list_reply_type reply;
         int unsigned at;
         at               = 32'(pos);
         reply.read_value = '0;
         reply.status     = ST_OK;
         case (fn)
            FN_PUSH_BACK: begin
               if (fill >= CAPACITY) reply.status = ST_FULL;
               else open_slot(fill, word);
            end
            FN_PUSH_FRONT: begin
               if (fill >= CAPACITY) reply.status = ST_FULL;
               else open_slot(0, word);
            end
            FN_POP_FRONT: begin
               if (fill == 0) reply.status = ST_RANGE;
               else close_slot(0);
            end
            FN_POP_BACK: begin
               if (fill == 0) reply.status = ST_RANGE;
               else close_slot(fill - 1);
            end
            FN_INSERT: begin
               // range check wins over the full check
               if (at > fill) reply.status = ST_RANGE;
               else if (fill >= CAPACITY) reply.status = ST_FULL;
               else open_slot(at, word);
            end
            FN_REMOVE_AT: begin
               if (at >= fill) reply.status = ST_RANGE;
               else close_slot(at);
            end
            FN_READ: begin
               if (at >= fill) reply.status = ST_RANGE;
               else begin
                  reply.read_value = VALUE_W'(slots[at]);
                  reads_ok++;
               end
            end
            default: fill = 0;
         endcase
         reply.entry_count = CNT_W'(fill);
         if (reply.status == ST_FULL) full_rejects++;
         if (reply.status == ST_RANGE) range_rejects++;
         if (fill > peak_fill) peak_fill = fill;
         requests++;
         replies_due = {replies_due, reply};
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_reply(logic [VALUE_W-1:0] rd, logic [CNT_W-1:0] cnt,
                       logic [STATUS_W-1:0] st);
         list_reply_type due;
         if (replies_due.size() == 0) begin
            report($sformatf("reply with none pending: read %h count %0d status %0d",
                             rd, cnt, st));
            return;
         end
         due = replies_due[0];
         replies_due.delete(0);
         if (rd !== due.read_value)
            report($sformatf("reply %0d: read_value %h, expected %h",
                             replies_seen, rd, due.read_value));
         if (cnt !== due.entry_count)
            report($sformatf("reply %0d: entry_count %0d, expected %0d",
                             replies_seen, cnt, due.entry_count));
         if (st !== due.status)
            report($sformatf("reply %0d: status %0d, expected %0d",
                             replies_seen, st, due.status));
         replies_seen++;
      endtask
   endclass

endpackage

/* dv/tb_positional_list_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine_unit
// Drives request items into the positional list engine and checks every
// response item against a shadow list: a directed pass over empty, boundary
// and out-of-range cases, then phases that grow, churn and drain the list
// with random positions and words, under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_positional_list_engine_unit;
   import ple_pkg::*;
   import ple_list_scoreboard_pkg::*;

   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_TAIL   = 100;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func;
   logic [POS_W-1:0]    req_position;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [VALUE_W-1:0]  rsp_read_value;
   logic [CNT_W-1:0]    rsp_entry_count;
   logic [STATUS_W-1:0] rsp_status;

   list_scoreboard_type sb;
   bit             quiet     = 1'b0;
   bit             idling_on = 1'b1;
   int             idle_cycles = 0;
   int             stall_left  = 0;
   int             item_idx;
   int             phase_left;
   mix_type        mix;

   positional_list_engine_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // receiver back-pressure in bursts
   always @(posedge clock) begin
      if (reset || quiet || !idling_on) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 10);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_reply(rsp_read_value, rsp_entry_count, rsp_status);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
   end

   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("TIMEOUT: no item moved for %0d cycles", STALL_LIMIT);
      $display("FAIL positional_list_engine_unit");
      $finish;
   end

   task automatic send_item(func_type fn, logic [POS_W-1:0] pos,
                            logic [VALUE_W-1:0] word);
      if (idling_on && !quiet && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= fn;
      req_position <= pos;
      req_value    <= word;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      sb.note_request(fn, pos, word);
   endtask

   // hold the sender off until every pending reply is back
   task automatic settle_list();
      req_valid <= 1'b0;
      while (sb.replies_due.size() != 0)
         @(posedge clock);
   endtask

   function automatic func_type pick_func(mix_type m);
      int r;
      r = $urandom_range(0, 99);
      case (m)
         MIX_GROW: begin
            if (r < 30) return FN_PUSH_BACK;
            if (r < 50) return FN_PUSH_FRONT;
            if (r < 75) return FN_INSERT;
            if (r < 88) return FN_READ;
            if (r < 92) return FN_POP_FRONT;
            if (r < 96) return FN_POP_BACK;
            return FN_REMOVE_AT;
         end
         MIX_SHRINK: begin
            if (r < 6)  return FN_PUSH_BACK;
            if (r < 10) return FN_PUSH_FRONT;
            if (r < 16) return FN_INSERT;
            if (r < 36) return FN_READ;
            if (r < 56) return FN_POP_FRONT;
            if (r < 72) return FN_POP_BACK;
            if (r < 98) return FN_REMOVE_AT;
            return FN_CLEAR;
         end
         default: begin
            if (r < 14) return FN_PUSH_BACK;
            if (r < 28) return FN_PUSH_FRONT;
            if (r < 42) return FN_INSERT;
            if (r < 58) return FN_READ;
            if (r < 70) return FN_POP_FRONT;
            if (r < 82) return FN_POP_BACK;
            if (r < 98) return FN_REMOVE_AT;
            return FN_CLEAR;
         end
      endcase
   endfunction

   // mostly legal positions, some edges, some anywhere in the field
   function automatic logic [POS_W-1:0] pick_position(func_type fn);
      int f;
      int r;
      f = sb.fill;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         if (fn == FN_INSERT || f == 0) return POS_W'($urandom_range(0, f));
         return POS_W'($urandom_range(0, f - 1));
      end
      if (r < 9) begin
         case ($urandom_range(0, 3))
            0:       return '0;
            1:       return POS_W'(f);
            2:       return POS_W'(f + 1);
            default: return POS_W'(CAPACITY);
         endcase
      end
      return POS_W'($urandom_range(0, 127));
   endfunction

   function automatic logic [VALUE_W-1:0] pick_word();
      if ($urandom_range(0, 9) != 0) return $urandom;
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         default: return 32'h0000_0001;
      endcase
   endfunction

   initial begin
      func_type fn;
      sb = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_func     <= FN_READ;
      req_position <= '0;
      req_value    <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty list, boundaries, insert at the end, out-of-range positions
      send_item(FN_POP_FRONT, 0, '0);
      send_item(FN_POP_BACK, 0, '0);
      send_item(FN_REMOVE_AT, 0, '0);
      send_item(FN_READ, 0, '0);
      send_item(FN_INSERT, 1, 32'h0000_0005);
      send_item(FN_INSERT, 127, 32'h5A5A_5A5A);
      send_item(FN_INSERT, 0, 32'hFFFF_FFFF);
      send_item(FN_PUSH_BACK, 0, 32'h0000_0000);
      send_item(FN_PUSH_FRONT, 127, 32'h8000_0000);
      send_item(FN_INSERT, 3, 32'h1234_5678);
      send_item(FN_READ, 0, '0);
      send_item(FN_READ, 1, '0);
      send_item(FN_READ, 2, '0);
      send_item(FN_READ, 3, '0);
      send_item(FN_READ, 4, '0);
      send_item(FN_READ, 127, '0);
      send_item(FN_REMOVE_AT, 4, '0);
      send_item(FN_REMOVE_AT, 1, '0);
      send_item(FN_POP_FRONT, 0, '0);
      send_item(FN_POP_BACK, 0, '0);
      send_item(FN_READ, 0, '0);
      send_item(FN_CLEAR, 0, '0);
      send_item(FN_CLEAR, 0, '0);
      send_item(FN_PUSH_BACK, 0, 32'hA5A5_A5A5);
      settle_list();

      mix        = MIX_SHRINK;
      phase_left = 0;
      for (item_idx = 0; item_idx < RANDOM_ITEMS; item_idx++) begin
         if (item_idx == RANDOM_ITEMS / 2)
            settle_list();
         quiet = (item_idx >= RANDOM_ITEMS - QUIET_TAIL);
         if (phase_left == 0) begin
            case (mix)
               MIX_GROW: mix = MIX_EVEN;
               MIX_EVEN: mix = MIX_SHRINK;
               default:  mix = MIX_GROW;
            endcase
            phase_left = $urandom_range(40, 120);
            idling_on  = ($urandom_range(0, 2) != 0);
         end
         phase_left--;
         fn = pick_func(mix);
         send_item(fn, pick_position(fn), pick_word());
      end

      settle_list();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests, %0d replies checked, list filled up to %0d of %0d.",
               sb.requests, sb.replies_seen, sb.peak_fill, CAPACITY);
      $display("Good reads %0d, full rejects %0d, range rejects %0d, mismatches %0d.",
               sb.reads_ok, sb.full_rejects, sb.range_rejects, sb.errors);
      if (sb.errors == 0)
         $display("PASS positional_list_engine_unit");
      else
         $display("FAIL positional_list_engine_unit");
      $finish;
   end

endmodule

/* files.f */
rtl/core/ple_pkg.sv
rtl/core/ple_ctrl.sv
rtl/core/ple_datapath.sv
rtl/core/positional_list_engine_unit.sv
dv/ple_list_scoreboard_pkg.sv
dv/tb_positional_list_engine_unit.sv
